FILE: src/prv_pkg.sv
// prv_pkg: shared constants, types and the byte-wide crc-32 step for the
// parameter record validator. No dependencies.
package prv_pkg;

  localparam int unsigned HEADER_BYTES     = 32;
  localparam int unsigned PAYLOAD_BYTES    = 128;
  localparam int unsigned MIN_RECORD_BYTES = 160;
  localparam int unsigned HEAD_BYTES       = 8;
  localparam int unsigned POS_W            = 16;
  localparam int unsigned HDR_IDX_W        = $clog2(HEADER_BYTES);
  localparam int unsigned HEAD_IDX_W       = $clog2(HEAD_BYTES);

  // header field offsets
  localparam int unsigned OFF_MAGIC     = 0;
  localparam int unsigned OFF_SCHEMA    = 4;
  localparam int unsigned OFF_HDR_SIZE  = 6;
  localparam int unsigned OFF_PAY_SIZE  = 8;
  localparam int unsigned OFF_FLAGS     = 10;
  localparam int unsigned OFF_SEQUENCE  = 12;
  localparam int unsigned OFF_VERSION   = 16;
  localparam int unsigned OFF_RESERVED0 = 18;
  localparam int unsigned OFF_PAY_CRC   = 20;
  localparam int unsigned OFF_HDR_CRC   = 24;
  localparam int unsigned OFF_RESERVED1 = 28;

  // payload head offsets
  localparam int unsigned OFF_PL_SCHEMA   = 0;
  localparam int unsigned OFF_PL_VERSION  = 2;
  localparam int unsigned OFF_PL_RESERVED = 6;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_MAGIC     = 2'd0,
    REG_SCHEMA    = 2'd1,
    REG_VERSION   = 2'd2,
    REG_FLAG_MASK = 2'd3
  } prv_reg_e;

  typedef enum logic [2:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_SHORT    = 3'd1,
    CAUSE_SIZES    = 3'd2,
    CAUSE_FLAG     = 3'd3,
    CAUSE_VERSION  = 3'd4,
    CAUSE_HDR_CRC  = 3'd5,
    CAUSE_PAY_CRC  = 3'd6,
    CAUSE_MISMATCH = 3'd7
  } prv_cause_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] schema;
    logic [15:0] version;
    logic [15:0] flag_mask;
  } prv_cfg_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/prv_if.sv
// prv_if: valid/ready channel interfaces for record bytes, results and
// register writes. No dependencies.
interface prv_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface prv_res_if;
  logic        valid;
  logic        ready;
  logic        record_ok;
  logic [2:0]  fail_cause;
  logic [31:0] sequence_number;
  modport source (output valid, output record_ok, output fail_cause,
                  output sequence_number, input ready);
  modport sink (input valid, input record_ok, input fail_cause,
                input sequence_number, output ready);
endinterface

interface prv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/prv_check.sv
// prv_check: evaluates the record checks in priority order from the captured
// header bytes, payload head bytes and final crc values. Uses prv_pkg.
module prv_check (
  input  logic [7:0]          hdr_i [prv_pkg::HEADER_BYTES],
  input  logic [7:0]          head_i [prv_pkg::HEAD_BYTES],
  input  prv_pkg::prv_cfg_t   cfg_i,
  input  logic                short_i,
  input  logic [31:0]         hdr_crc_i,
  input  logic [31:0]         pay_crc_i,
  output prv_pkg::prv_cause_e cause_o
);
  import prv_pkg::*;

  logic [31:0] magic, seq_unused_w, pay_crc_w, hdr_crc_w;
  logic [15:0] schema, version, hdr_size, pay_size, flags, rsv0, rsv1;
  logic [15:0] pl_schema, pl_version, pl_rsv;
  logic        sizes_bad, flag_bad, ver_bad, hcrc_bad, pcrc_bad, pl_bad;

  assign magic     = {hdr_i[OFF_MAGIC+3], hdr_i[OFF_MAGIC+2],
                      hdr_i[OFF_MAGIC+1], hdr_i[OFF_MAGIC]};
  assign pay_crc_w = {hdr_i[OFF_PAY_CRC+3], hdr_i[OFF_PAY_CRC+2],
                      hdr_i[OFF_PAY_CRC+1], hdr_i[OFF_PAY_CRC]};
  assign hdr_crc_w = {hdr_i[OFF_HDR_CRC+3], hdr_i[OFF_HDR_CRC+2],
                      hdr_i[OFF_HDR_CRC+1], hdr_i[OFF_HDR_CRC]};
  assign seq_unused_w = '0;
  assign schema    = {hdr_i[OFF_SCHEMA+1], hdr_i[OFF_SCHEMA]};
  assign hdr_size  = {hdr_i[OFF_HDR_SIZE+1], hdr_i[OFF_HDR_SIZE]};
  assign pay_size  = {hdr_i[OFF_PAY_SIZE+1], hdr_i[OFF_PAY_SIZE]};
  assign flags     = {hdr_i[OFF_FLAGS+1], hdr_i[OFF_FLAGS]};
  assign version   = {hdr_i[OFF_VERSION+1], hdr_i[OFF_VERSION]};
  assign rsv0      = {hdr_i[OFF_RESERVED0+1], hdr_i[OFF_RESERVED0]};
  assign rsv1      = {hdr_i[OFF_RESERVED1+1], hdr_i[OFF_RESERVED1]};
  assign pl_schema  = {head_i[OFF_PL_SCHEMA+1], head_i[OFF_PL_SCHEMA]};
  assign pl_version = {head_i[OFF_PL_VERSION+1], head_i[OFF_PL_VERSION]};
  assign pl_rsv     = {head_i[OFF_PL_RESERVED+1], head_i[OFF_PL_RESERVED]};

  assign sizes_bad = (magic != cfg_i.magic) || (hdr_size != 16'(HEADER_BYTES)) ||
                     (pay_size != 16'(PAYLOAD_BYTES));
  assign flag_bad  = (flags & cfg_i.flag_mask) == 16'd0;
  assign ver_bad   = (schema != cfg_i.schema) || (version != cfg_i.version) ||
                     (rsv0 != 16'd0) || (rsv1 != 16'd0);
  assign hcrc_bad  = hdr_crc_w != ~hdr_crc_i;
  assign pcrc_bad  = (pay_crc_w ^ seq_unused_w) != ~pay_crc_i;
  assign pl_bad    = (pl_schema != schema) || (pl_version != version) || (pl_rsv != 16'd0);

  always_comb begin
    if (short_i)        cause_o = CAUSE_SHORT;
    else if (sizes_bad) cause_o = CAUSE_SIZES;
    else if (flag_bad)  cause_o = CAUSE_FLAG;
    else if (ver_bad)   cause_o = CAUSE_VERSION;
    else if (hcrc_bad)  cause_o = CAUSE_HDR_CRC;
    else if (pcrc_bad)  cause_o = CAUSE_PAY_CRC;
    else if (pl_bad)    cause_o = CAUSE_MISMATCH;
    else                cause_o = CAUSE_OK;
  end

endmodule

FILE: src/parameter_record_validator.sv
// parameter_record_validator: top level. Uses prv_pkg, the channel
// interfaces in prv_if.sv and the check logic in prv_check.
//
// Takes a stored parameter record one byte per transfer on in_if and gives
// one result on out_if for the byte marked last: pass or fail, the first
// failing check and the header sequence number. A byte can be transferred in
// every cycle unless the stall below holds it; each byte is registered, then
// the crc step, field capture and (on the last byte) the checks run from the
// input register and the result register loads from the checks. The only
// stall comes from the result register: when a result is still waiting on
// out_if, a new last byte is held in the input register until that result is
// taken, while other bytes keep flowing. Register writes on cfg_if are always
// accepted at once (ready is tied high) and are expected only while no record
// is in progress.
module parameter_record_validator (
  input  logic  clk_i,
  input  logic  rst_ni,
  prv_cfg_if.sink   cfg_if,
  prv_rec_if.sink   in_if,
  prv_res_if.source out_if
);
  import prv_pkg::*;

  prv_cfg_t cfg_q, cfg_d;

  logic       in_v_q, in_v_d;
  logic [7:0] byte_q;
  logic       last_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      hcrc_q, hcrc_d, pcrc_q, pcrc_d, hcrc_upd, pcrc_upd;
  logic [7:0]       hdr_q [HEADER_BYTES];
  logic [7:0]       head_q [HEAD_BYTES];
  logic [7:0]       head_upd [HEAD_BYTES];

  logic        out_v_q, out_v_d;
  logic        ok_q;
  logic [2:0]  cause_q;
  logic [31:0] seq_q;

  logic             advance, step, finish;
  logic             in_hdr, in_pay, in_head, in_crc_gap, short_rec;
  logic [POS_W:0]   count;
  logic [HEAD_IDX_W-1:0] head_idx;
  prv_cause_e       cause;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (prv_reg_e'(cfg_if.index))
        REG_MAGIC:     cfg_d.magic     = cfg_if.data;
        REG_SCHEMA:    cfg_d.schema    = cfg_if.data[15:0];
        REG_VERSION:   cfg_d.version   = cfg_if.data[15:0];
        REG_FLAG_MASK: cfg_d.flag_mask = cfg_if.data[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // pipeline control: the input register moves on unless it holds a last
  // byte and the result register is occupied and not being taken
  assign advance     = !last_q || !out_v_q || out_if.ready;
  assign step        = in_v_q && advance;
  assign finish      = step && last_q;
  assign in_if.ready = !in_v_q || advance;
  assign in_v_d      = (in_if.valid && in_if.ready) ? 1'b1 : (step ? 1'b0 : in_v_q);

  // byte classification
  assign in_hdr     = pos_q < POS_W'(HEADER_BYTES);
  assign in_pay     = !in_hdr && (pos_q < POS_W'(HEADER_BYTES + PAYLOAD_BYTES));
  assign in_head    = !in_hdr && (pos_q < POS_W'(HEADER_BYTES + HEAD_BYTES));
  assign in_crc_gap = (pos_q >= POS_W'(OFF_HDR_CRC)) && (pos_q < POS_W'(OFF_HDR_CRC + 4));
  assign head_idx   = HEAD_IDX_W'(pos_q - POS_W'(HEADER_BYTES));
  assign count      = {1'b0, pos_q} + (POS_W+1)'(1);
  assign short_rec  = count < (POS_W+1)'(MIN_RECORD_BYTES);

  assign hcrc_upd = in_hdr ? crc_byte(hcrc_q, in_crc_gap ? 8'd0 : byte_q) : hcrc_q;
  assign pcrc_upd = in_pay ? crc_byte(pcrc_q, byte_q) : pcrc_q;

  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      head_upd[i] = head_q[i];
    end
    if (in_head) begin
      head_upd[head_idx] = byte_q;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    hcrc_d = hcrc_q;
    pcrc_d = pcrc_q;
    if (step) begin
      if (last_q) begin
        pos_d  = '0;
        hcrc_d = CRC_INIT;
        pcrc_d = CRC_INIT;
      end else begin
        pos_d  = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
        hcrc_d = hcrc_upd;
        pcrc_d = pcrc_upd;
      end
    end
  end

  prv_check u_check (
    .hdr_i     (hdr_q),
    .head_i    (head_upd),
    .cfg_i     (cfg_q),
    .short_i   (short_rec),
    .hdr_crc_i (hcrc_upd),
    .pay_crc_i (pcrc_upd),
    .cause_o   (cause)
  );

  assign out_v_d = finish ? 1'b1 : (out_if.ready ? 1'b0 : out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{magic: 32'd0, schema: 16'd0, version: 16'd0, flag_mask: 16'd1};
      in_v_q  <= 1'b0;
      pos_q   <= '0;
      hcrc_q  <= CRC_INIT;
      pcrc_q  <= CRC_INIT;
      out_v_q <= 1'b0;
    end else begin
      cfg_q   <= cfg_d;
      in_v_q  <= in_v_d;
      pos_q   <= pos_d;
      hcrc_q  <= hcrc_d;
      pcrc_q  <= pcrc_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      byte_q <= in_if.data_byte;
      last_q <= in_if.last_byte;
    end
    if (step && in_hdr) begin
      hdr_q[pos_q[HDR_IDX_W-1:0]] <= byte_q;
    end
    if (step && in_head) begin
      head_q[head_idx] <= byte_q;
    end
    if (finish) begin
      ok_q    <= cause == CAUSE_OK;
      cause_q <= cause;
      seq_q   <= short_rec ? 32'd0 :
                 {hdr_q[OFF_SEQUENCE+3], hdr_q[OFF_SEQUENCE+2],
                  hdr_q[OFF_SEQUENCE+1], hdr_q[OFF_SEQUENCE]};
    end
  end

  assign out_if.valid           = out_v_q;
  assign out_if.record_ok       = ok_q;
  assign out_if.fail_cause      = cause_q;
  assign out_if.sequence_number = seq_q;

endmodule

FILE: src/prv_checker.sv
// prv_checker: port-level assertions for parameter_record_validator, bound
// to the top level below. Uses prv_pkg for the cause codes.
module prv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_ok_i,
  input logic [2:0]  out_cause_i,
  input logic [31:0] out_seq_i
);
  import prv_pkg::*;

  // a pending result is held until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_ok_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_ok_i == (out_cause_i == CAUSE_OK)))
    else $error("record_ok disagrees with fail_cause");

  a_short_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_cause_i == CAUSE_SHORT) |-> (out_seq_i == 32'd0))
    else $error("short record with nonzero sequence number");

  // input only stalls behind a result that is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output is free");

  // a new result follows the transfer of a last byte
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result without a last-byte transfer");

endmodule

bind parameter_record_validator prv_checker u_prv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_last_i   (in_if.last_byte),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_ok_i    (out_if.record_ok),
  .out_cause_i (out_if.fail_cause),
  .out_seq_i   (out_if.sequence_number)
);

FILE: tb/tb_top.sv
// tb_top: self-checking bench for parameter_record_validator. Streams
// records byte by byte and predicts each verdict. Needs prv_pkg, the channel
// interfaces in prv_if.sv and the validator top level.
`timescale 1ns / 1ps

module tb_top;
  import prv_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 20_000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned STALL_BURST    = 16;
  localparam int unsigned IDLE_BURST     = 8;
  localparam int unsigned TRAIL_BYTES    = 8;

  // ways a generated record can be damaged
  localparam int unsigned FLAW_MAGIC    = 1;
  localparam int unsigned FLAW_SIZES    = 2;
  localparam int unsigned FLAW_FLAGS    = 4;
  localparam int unsigned FLAW_FIELDS   = 8;
  localparam int unsigned FLAW_HDR_CRC  = 16;
  localparam int unsigned FLAW_PAY_CRC  = 32;
  localparam int unsigned FLAW_PAY_HEAD = 64;

  localparam int unsigned FILL_RANDOM = 0;
  localparam int unsigned FILL_ZERO   = 1;
  localparam int unsigned FILL_ONES   = 2;

  typedef struct {
    logic        ok;
    prv_cause_e  cause;
    logic [31:0] seq;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #4 clk_i = ~clk_i;

  prv_cfg_if cfg_ch ();
  prv_rec_if rec_ch ();
  prv_res_if res_ch ();

  parameter_record_validator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch),
    .in_if  (rec_ch),
    .out_if (res_ch)
  );

  // predictor state
  logic [31:0] cfg_magic;
  logic [15:0] cfg_schema, cfg_version, cfg_mask;
  logic [15:0] rec_pos;
  logic [31:0] hdr_crc_run, pay_crc_run;
  logic [7:0]  hdr_mem [HEADER_BYTES];
  logic [7:0]  head_mem [HEAD_BYTES];

  verdict_t    verdict_q [$];
  logic [7:0]  rec_buf [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fault_count    = 0;
  int unsigned verdicts_seen  = 0;
  int unsigned records_sent   = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ 32'hEDB8_8320;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [15:0] hdr16(input int unsigned off);
    return {hdr_mem[off+1], hdr_mem[off]};
  endfunction

  function automatic logic [31:0] hdr32(input int unsigned off);
    return {hdr_mem[off+3], hdr_mem[off+2], hdr_mem[off+1], hdr_mem[off]};
  endfunction

  function automatic logic [15:0] nonzero16();
    logic [15:0] v;
    do v = 16'($urandom); while (v == 16'd0);
    return v;
  endfunction

  function automatic void clear_record_state();
    rec_pos     = '0;
    hdr_crc_run = '1;
    pay_crc_run = '1;
  endfunction

  // follow one accepted byte; on the last byte queue the verdict
  function automatic void absorb_record_byte(input logic [7:0] d, input logic is_last);
    int unsigned cnt;
    logic [15:0] sch, ver;
    verdict_t v;
    if (rec_pos < HEADER_BYTES) begin
      hdr_mem[rec_pos[HDR_IDX_W-1:0]] = d;
      // crc field itself counts as zero
      if (rec_pos >= OFF_HDR_CRC && rec_pos < OFF_HDR_CRC + 4)
        hdr_crc_run = crc32_step(hdr_crc_run, 8'h00);
      else
        hdr_crc_run = crc32_step(hdr_crc_run, d);
    end else if (rec_pos < HEADER_BYTES + PAYLOAD_BYTES) begin
      if (rec_pos - HEADER_BYTES < HEAD_BYTES)
        head_mem[HEAD_IDX_W'(rec_pos - 16'(HEADER_BYTES))] = d;
      pay_crc_run = crc32_step(pay_crc_run, d);
    end
    cnt = int'(rec_pos) + 1;
    if (rec_pos != 16'hFFFF) rec_pos = rec_pos + 16'd1;
    if (!is_last) return;

    v.seq = '0;
    if (cnt < MIN_RECORD_BYTES) begin
      v.cause = CAUSE_SHORT;
    end else begin
      sch   = hdr16(OFF_SCHEMA);
      ver   = hdr16(OFF_VERSION);
      v.seq = hdr32(OFF_SEQUENCE);
      if (hdr32(OFF_MAGIC) != cfg_magic || hdr16(OFF_HDR_SIZE) != HEADER_BYTES ||
          hdr16(OFF_PAY_SIZE) != PAYLOAD_BYTES)
        v.cause = CAUSE_SIZES;
      else if ((hdr16(OFF_FLAGS) & cfg_mask) == 16'd0)
        v.cause = CAUSE_FLAG;
      else if (sch != cfg_schema || ver != cfg_version ||
               hdr16(OFF_RESERVED0) != 16'd0 || hdr16(OFF_RESERVED1) != 16'd0)
        v.cause = CAUSE_VERSION;
      else if (hdr32(OFF_HDR_CRC) != ~hdr_crc_run)
        v.cause = CAUSE_HDR_CRC;
      else if (hdr32(OFF_PAY_CRC) != ~pay_crc_run)
        v.cause = CAUSE_PAY_CRC;
      else if ({head_mem[OFF_PL_SCHEMA+1], head_mem[OFF_PL_SCHEMA]} != sch ||
               {head_mem[OFF_PL_VERSION+1], head_mem[OFF_PL_VERSION]} != ver ||
               {head_mem[OFF_PL_RESERVED+1], head_mem[OFF_PL_RESERVED]} != 16'd0)
        v.cause = CAUSE_MISMATCH;
      else
        v.cause = CAUSE_OK;
    end
    v.ok = (v.cause == CAUSE_OK);
    verdict_q.push_back(v);
    clear_record_state();
  endfunction

  // well-formed record for the current registers, then damaged, cut or extended as asked
  function automatic void build_record(input int unsigned flaws, input logic [31:0] seq,
                                       input int unsigned fill, input int unsigned cut,
                                       input int unsigned extra);
    logic [255:0] hdr;
    logic [7:0]   pay [PAYLOAD_BYTES];
    logic [31:0]  magic, crc;
    logic [15:0]  sch, ver, hsz, psz, flags, res0, res1;
    int unsigned  idx;
    magic = cfg_magic;
    sch   = cfg_schema;
    ver   = cfg_version;
    hsz   = 16'(HEADER_BYTES);
    psz   = 16'(PAYLOAD_BYTES);
    res0  = '0;
    res1  = '0;
    flags = 16'($urandom);
    if (cfg_mask != 16'd0 && (flags & cfg_mask) == 16'd0) begin
      do idx = $urandom_range(15); while (!cfg_mask[idx]);
      flags[idx] = 1'b1;
    end
    if (flaws & FLAW_MAGIC) magic = magic ^ (32'h1 << $urandom_range(31));
    if (flaws & FLAW_SIZES) begin
      case ($urandom_range(2))
        0: hsz = hsz ^ nonzero16();
        1: psz = psz ^ nonzero16();
        default: begin
          hsz = hsz ^ nonzero16();
          psz = psz ^ nonzero16();
        end
      endcase
    end
    if (flaws & FLAW_FLAGS) flags = flags & ~cfg_mask;
    if (flaws & FLAW_FIELDS) begin
      case ($urandom_range(3))
        0: sch = sch ^ nonzero16();
        1: ver = ver ^ nonzero16();
        2: res0 = nonzero16();
        default: res1 = nonzero16();
      endcase
    end

    for (int i = 0; i < PAYLOAD_BYTES; i++)
      pay[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
    pay[OFF_PL_SCHEMA]     = sch[7:0];
    pay[OFF_PL_SCHEMA+1]   = sch[15:8];
    pay[OFF_PL_VERSION]    = ver[7:0];
    pay[OFF_PL_VERSION+1]  = ver[15:8];
    pay[OFF_PL_RESERVED]   = 8'h00;
    pay[OFF_PL_RESERVED+1] = 8'h00;
    if (flaws & FLAW_PAY_HEAD) begin
      case ($urandom_range(2))
        0: idx = OFF_PL_SCHEMA + $urandom_range(1);
        1: idx = OFF_PL_VERSION + $urandom_range(1);
        default: idx = OFF_PL_RESERVED + $urandom_range(1);
      endcase
      pay[idx] = pay[idx] ^ (8'h1 << $urandom_range(7));
    end

    crc = '1;
    for (int i = 0; i < PAYLOAD_BYTES; i++) crc = crc32_step(crc, pay[i]);
    crc = ~crc;
    if (flaws & FLAW_PAY_CRC) crc = crc ^ (32'h1 << $urandom_range(31));

    hdr = '0;
    hdr[8*OFF_MAGIC     +: 32] = magic;
    hdr[8*OFF_SCHEMA    +: 16] = sch;
    hdr[8*OFF_HDR_SIZE  +: 16] = hsz;
    hdr[8*OFF_PAY_SIZE  +: 16] = psz;
    hdr[8*OFF_FLAGS     +: 16] = flags;
    hdr[8*OFF_SEQUENCE  +: 32] = seq;
    hdr[8*OFF_VERSION   +: 16] = ver;
    hdr[8*OFF_RESERVED0 +: 16] = res0;
    hdr[8*OFF_PAY_CRC   +: 32] = crc;
    hdr[8*OFF_RESERVED1 +: 16] = res1;
    crc = '1;
    for (int i = 0; i < HEADER_BYTES; i++) crc = crc32_step(crc, hdr[8*i +: 8]);
    crc = ~crc;
    if (flaws & FLAW_HDR_CRC) crc = crc ^ (32'h1 << $urandom_range(31));
    hdr[8*OFF_HDR_CRC +: 32] = crc;

    rec_buf.delete();
    for (int i = 0; i < HEADER_BYTES; i++) rec_buf.push_back(hdr[8*i +: 8]);
    for (int i = 0; i < PAYLOAD_BYTES; i++) rec_buf.push_back(pay[i]);
    if (cut != 0) begin
      while (rec_buf.size() > cut) void'(rec_buf.pop_back());
    end
    for (int unsigned i = 0; i < extra; i++) rec_buf.push_back(8'($urandom));
  endfunction

  function automatic void build_noise(input int unsigned len);
    rec_buf.delete();
    for (int unsigned i = 0; i < len; i++) rec_buf.push_back(8'($urandom));
  endfunction

  // entered at a falling edge; valid stays up for a following byte
  task automatic send_byte(input logic [7:0] d, input logic is_last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      rec_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    rec_ch.valid     <= 1'b1;
    rec_ch.data_byte <= d;
    rec_ch.last_byte <= is_last;
    @(posedge clk_i);
    while (!rec_ch.ready) @(posedge clk_i);
    absorb_record_byte(d, is_last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_buf.size(); i++) send_byte(rec_buf[i], i == rec_buf.size() - 1);
    records_sent++;
  endtask

  // back-to-back tiny records, each one a result
  task automatic send_short_burst(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      build_noise($urandom_range(1, 3));
      send_record();
    end
  endtask

  task automatic wait_idle();
    rec_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input prv_reg_e idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      REG_MAGIC:     cfg_magic   = val;
      REG_SCHEMA:    cfg_schema  = val[15:0];
      REG_VERSION:   cfg_version = val[15:0];
      REG_FLAG_MASK: cfg_mask    = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // upper bits of the 16-bit registers carry junk that must be dropped
  task automatic set_config(input logic [31:0] magic, input logic [15:0] sch,
                            input logic [15:0] ver, input logic [15:0] mask);
    write_reg(REG_MAGIC, magic);
    write_reg(REG_SCHEMA, {16'($urandom), sch});
    write_reg(REG_VERSION, {16'($urandom), ver});
    write_reg(REG_FLAG_MASK, {16'($urandom), mask});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_config();
    build_record(0, $urandom, FILL_RANDOM, 0, 0);
    send_record();
    build_record(0, $urandom, FILL_RANDOM, 1, 0);
    send_record();
    wait_idle();
  endtask

  // magic or size fault wins over later faults; a three-byte short record
  task automatic test_each_check();
    int unsigned first;
    first = ($urandom_range(1) == 0) ? FLAW_MAGIC : FLAW_SIZES;
    set_config($urandom, 16'($urandom), 16'($urandom), nonzero16());
    build_record(first | FLAW_FLAGS | FLAW_PAY_CRC, $urandom, FILL_RANDOM, 0, 0);
    send_record();
    build_record(0, $urandom, FILL_RANDOM, 3, 0);
    send_record();
    wait_idle();
  endtask

  task automatic test_flag_mask();
    set_config($urandom, 16'($urandom), 16'($urandom), 16'h0000);
    build_record(0, 32'h0, FILL_ZERO, 0, 0);
    send_record();
    wait_idle();
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 72;
    recv_stall_pct = 0;
    set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    build_record(FLAW_FIELDS | FLAW_HDR_CRC, 32'hFFFF_FFFF, FILL_ONES, 0, 0);
    send_record();
    build_record(FLAW_HDR_CRC | FLAW_PAY_CRC | FLAW_PAY_HEAD, $urandom, FILL_RANDOM, 0, 0);
    send_record();
    wait_idle();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 72;
    set_config(32'h0, 16'h0, 16'h0, 16'h0001);
    build_record(FLAW_PAY_CRC | FLAW_PAY_HEAD, $urandom, FILL_ZERO, 0, 0);
    send_record();
    send_short_burst(STALL_BURST);
    wait_idle();
  endtask

  // trailing bytes past the payload are ignored
  task automatic test_both_idle();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    set_config($urandom, 16'($urandom), 16'($urandom), nonzero16());
    build_record(FLAW_PAY_HEAD, $urandom, FILL_RANDOM, 0, TRAIL_BYTES);
    send_record();
    send_short_burst(IDLE_BURST);
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  always @(negedge clk_i) begin
    res_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result ok=%0b cause=%0d seq=%08h", $time,
                 res_ch.record_ok, res_ch.fail_cause, res_ch.sequence_number);
      end else begin
        want = verdict_q.pop_front();
        if (res_ch.record_ok !== want.ok) begin
          fault_count++;
          $display("%0t: record_ok expected %0b got %0b", $time, want.ok, res_ch.record_ok);
        end
        if (res_ch.fail_cause !== want.cause) begin
          fault_count++;
          $display("%0t: fail_cause expected %0d got %0d", $time, want.cause,
                   res_ch.fail_cause);
        end
        if (res_ch.sequence_number !== want.seq) begin
          fault_count++;
          $display("%0t: sequence_number expected %08h got %08h", $time, want.seq,
                   res_ch.sequence_number);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped at cycle limit, %0d results outstanding", $time,
               verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    rec_ch.valid     = 1'b0;
    rec_ch.data_byte = '0;
    rec_ch.last_byte = 1'b0;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_MAGIC;
    cfg_ch.data      = '0;
    cfg_magic        = '0;
    cfg_schema       = '0;
    cfg_version      = '0;
    cfg_mask         = 16'h0001;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
    foreach (head_mem[i]) head_mem[i] = '0;
    clear_record_state();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_config();
    test_each_check();
    test_flag_mask();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    wait_idle();

    $display("covered %0d records / %0d bytes: every fail cause, stacked faults,",
             records_sent, bytes_sent);
    $display("short and overlong records, register extremes and four pacing modes;");
    $display("%0d verdicts compared", verdicts_seen);
    if (fault_count == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
